[rtl/lkv_pkg.sv]
// Shared constants, types and control structs for the LRU key-value cache.
// No dependencies; the files that use it refer to it by scoped names.
package lkv_pkg;

    // Store geometry
    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int RANK_W  = IDX_W;
    localparam int OCC_W   = $clog2(ENTRIES + 1);

    // Field widths
    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int CAP_W = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // Operation codes
    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    typedef logic [IDX_W-1:0]                   t_idx;
    typedef logic [ENTRIES-1:0][RANK_W-1:0]     t_rank_vec;

    // Sequencer to compare unit
    typedef struct packed {
        logic clear;
        logic cmp_en;
        t_idx cmp_idx;
    } t_scan_ctl;

    // Compare unit results, held until the next clear
    typedef struct packed {
        logic               hit;
        t_idx               hit_idx;
        logic [VAL_W-1:0]   hit_val;
        logic               old_found;
        t_idx               old_idx;
        logic [RANK_W-1:0]  old_rank;
        logic [KEY_W-1:0]   old_key;
        logic               free_found;
        t_idx               free_idx;
    } t_scan_res;

    // Recency update command
    typedef struct packed {
        logic en;
        logic touch;
        logic insert;
        logic evict;
        t_idx hit_idx;
        t_idx old_idx;
        t_idx ins_idx;
    } t_rank_cmd;

endpackage

[rtl/lkv_ifs.sv]
// Channel interfaces of the LRU key-value cache: request, response, configuration.
// Depends on lkv_pkg for field widths.
interface lkv_req_if;
    logic                             valid;
    logic                             ready;
    logic                             op;
    logic signed [lkv_pkg::KEY_W-1:0] lookup_key;
    logic signed [lkv_pkg::VAL_W-1:0] write_value;

    modport source (output valid, output op, output lookup_key, output write_value,
                    input ready);
    modport sink   (input valid, input op, input lookup_key, input write_value,
                    output ready);
endinterface

interface lkv_rsp_if;
    logic                             valid;
    logic                             ready;
    logic                             found;
    logic signed [lkv_pkg::VAL_W-1:0] read_value;
    logic                             evicted;
    logic signed [lkv_pkg::KEY_W-1:0] evicted_key;

    modport source (output valid, output found, output read_value, output evicted,
                    output evicted_key, input ready);
    modport sink   (input valid, input found, input read_value, input evicted,
                    input evicted_key, output ready);
endinterface

interface lkv_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [lkv_pkg::CAP_W-1:0]        active_capacity;

    modport source (output valid, output active_capacity, input ready);
    modport sink   (input valid, input active_capacity, output ready);
endinterface

[rtl/lkv_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lkv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                          i_wr_data,
    input  logic                                      i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                          o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/lkv_scan_unit.sv]
// Shared compare unit: one stored entry per cycle, while compare is enabled, against
// the request key, tracking first hit, least recent entry and first free slot. Uses lkv_pkg.
module lkv_scan_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  lkv_pkg::t_scan_ctl           i_ctl,
    input  logic [lkv_pkg::KEY_W-1:0]    i_key,
    input  logic [lkv_pkg::KEY_W-1:0]    i_key_rd,
    input  logic [lkv_pkg::VAL_W-1:0]    i_val_rd,
    input  logic [lkv_pkg::ENTRIES-1:0]  i_valid,
    input  lkv_pkg::t_rank_vec           i_rank,
    output lkv_pkg::t_scan_res           o_res
);

    lkv_pkg::t_scan_res              r_res;
    lkv_pkg::t_scan_res              n_res;
    logic                            w_vld;
    logic [lkv_pkg::RANK_W-1:0]      w_rank;

    assign w_vld  = i_valid[i_ctl.cmp_idx];
    assign w_rank = i_rank[i_ctl.cmp_idx];

    // Fold the entry under compare into the running results
    always_comb begin
        n_res = r_res;
        if (i_ctl.clear) begin
            n_res = '0;
        end else if (i_ctl.cmp_en) begin
            if (w_vld && (i_key_rd == i_key) && !r_res.hit) begin
                n_res.hit     = 1'b1;
                n_res.hit_idx = i_ctl.cmp_idx;
                n_res.hit_val = i_val_rd;
            end
            if (w_vld && (!r_res.old_found || (w_rank > r_res.old_rank))) begin
                n_res.old_found = 1'b1;
                n_res.old_idx   = i_ctl.cmp_idx;
                n_res.old_rank  = w_rank;
                n_res.old_key   = i_key_rd;
            end
            if (!w_vld && !r_res.free_found) begin
                n_res.free_found = 1'b1;
                n_res.free_idx   = i_ctl.cmp_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res <= '0;
        end else begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

[rtl/lkv_rank_array.sv]
// Valid marks, recency ranks and occupancy count, updated once per enabled command.
// Uses lkv_pkg.
module lkv_rank_array (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lkv_pkg::t_rank_cmd            i_cmd,
    output logic [lkv_pkg::ENTRIES-1:0]   o_valid,
    output lkv_pkg::t_rank_vec            o_rank,
    output logic [lkv_pkg::OCC_W-1:0]     o_occ
);

    logic [lkv_pkg::ENTRIES-1:0]  r_valid;
    logic [lkv_pkg::ENTRIES-1:0]  n_valid;
    lkv_pkg::t_rank_vec           r_rank;
    lkv_pkg::t_rank_vec           n_rank;
    logic [lkv_pkg::OCC_W-1:0]    r_occ;
    logic [lkv_pkg::OCC_W-1:0]    n_occ;
    logic [lkv_pkg::RANK_W-1:0]   w_age;
    logic [lkv_pkg::ENTRIES-1:0]  w_kept;

    assign w_age = r_rank[i_cmd.hit_idx];

    // Entries left after an eviction
    always_comb begin
        w_kept = r_valid;
        if (i_cmd.evict) begin
            w_kept[i_cmd.old_idx] = 1'b0;
        end
    end

    // Touch ages younger entries; insert ages every kept entry
    always_comb begin
        n_valid = r_valid;
        n_rank  = r_rank;
        n_occ   = r_occ;
        if (i_cmd.en) begin
            if (i_cmd.touch) begin
                for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
                    if (r_valid[i] && (i_cmd.hit_idx != lkv_pkg::IDX_W'(i))
                        && (r_rank[i] < w_age)) begin
                        n_rank[i] = r_rank[i] + lkv_pkg::RANK_W'(1);
                    end
                end
                n_rank[i_cmd.hit_idx] = '0;
            end else if (i_cmd.insert) begin
                for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
                    if (w_kept[i]) begin
                        n_rank[i] = r_rank[i] + lkv_pkg::RANK_W'(1);
                    end
                end
                n_valid                = w_kept;
                n_valid[i_cmd.ins_idx] = 1'b1;
                n_rank[i_cmd.ins_idx]  = '0;
                n_occ = r_occ + lkv_pkg::OCC_W'(1)
                        - lkv_pkg::OCC_W'(i_cmd.evict);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_occ   <= '0;
        end else begin
            r_valid <= n_valid;
            r_occ   <= n_occ;
        end
    end

    // Ranks are only read for valid entries
    always_ff @(posedge i_clk) begin
        r_rank <= n_rank;
    end

    assign o_valid = r_valid;
    assign o_rank  = r_rank;
    assign o_occ   = r_occ;

endmodule

[rtl/lru_key_value_cache_core.sv]
// LRU key-value cache, top level. Uses lkv_pkg, lkv_ifs, lkv_ram, lkv_scan_unit,
// lkv_rank_array. An accepted request passes a scan state with one RAM read per
// entry (16) through the shared compare unit, a drain state for the registered
// read and an update state that registers the response; ready returns after the
// update. A held response stalls the next update.
// Synchronous active-low reset clears valid marks, occupancy, state, capacity 16.
module lru_key_value_cache_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lkv_req_if.sink     i_req,
    lkv_rsp_if.source   o_rsp,
    lkv_cfg_if.sink     i_cfg
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_UPD  = 2'd3;

    logic [1:0]                      r_state;
    logic [1:0]                      n_state;
    lkv_pkg::t_idx                   r_idx;
    lkv_pkg::t_idx                   r_pidx;
    logic                            r_op;
    logic [lkv_pkg::KEY_W-1:0]       r_key;
    logic [lkv_pkg::VAL_W-1:0]       r_wval;
    logic [lkv_pkg::CAP_W-1:0]       r_cap;

    logic                            r_out_valid;
    logic                            r_out_found;
    logic [lkv_pkg::VAL_W-1:0]       r_out_val;
    logic                            r_out_ev;
    logic [lkv_pkg::KEY_W-1:0]       r_out_evkey;

    logic                            w_req_acc;
    logic                            w_upd_fire;
    logic                            w_evict;
    lkv_pkg::t_idx                   w_ins_idx;
    logic [31:0]                     w_cap_eff;
    logic [lkv_pkg::KEY_W-1:0]       w_key_rd;
    logic [lkv_pkg::VAL_W-1:0]       w_val_rd;
    logic [lkv_pkg::ENTRIES-1:0]     w_valid;
    lkv_pkg::t_rank_vec              w_rank;
    logic [lkv_pkg::OCC_W-1:0]       w_occ;
    lkv_pkg::t_scan_ctl              w_ctl;
    lkv_pkg::t_scan_res              w_res;
    lkv_pkg::t_rank_cmd              w_cmd;
    logic                            w_key_we;
    logic                            w_val_we;
    lkv_pkg::t_idx                   w_val_waddr;

    // Handshakes
    assign i_req.ready = (r_state == ST_IDLE);
    assign w_req_acc   = i_req.valid && i_req.ready;
    assign i_cfg.ready = 1'b1;
    assign w_upd_fire  = (r_state == ST_UPD) && (!r_out_valid || o_rsp.ready);

    // Capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= lkv_pkg::CAP_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_cap <= i_cfg.active_capacity;
        end
    end

    // Effective capacity: zero acts as one, saturates at store size
    always_comb begin
        w_cap_eff = 32'(r_cap);
        if (w_cap_eff == 32'd0) begin
            w_cap_eff = 32'd1;
        end
        if (w_cap_eff > 32'(lkv_pkg::ENTRIES)) begin
            w_cap_eff = 32'(lkv_pkg::ENTRIES);
        end
    end

    // Sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_req_acc) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_idx == lkv_pkg::IDX_W'(lkv_pkg::ENTRIES - 1)) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_UPD;
            end
            ST_UPD: begin
                if (w_upd_fire) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            if (w_req_acc) begin
                r_idx <= '0;
            end else if (r_state == ST_SCAN) begin
                r_idx <= r_idx + lkv_pkg::IDX_W'(1);
            end
        end
    end

    // Request latch and compare index pipeline
    always_ff @(posedge i_clk) begin
        if (w_req_acc) begin
            r_op   <= i_req.op;
            r_key  <= i_req.lookup_key;
            r_wval <= i_req.write_value;
        end
        r_pidx <= r_idx;
    end

    assign w_ctl.clear   = w_req_acc;
    assign w_ctl.cmp_en  = ((r_state == ST_SCAN) && (r_idx != '0)) || (r_state == ST_DRAIN);
    assign w_ctl.cmp_idx = r_pidx;

    // Update decisions
    assign w_evict = (r_op == lkv_pkg::OP_PUT) && !w_res.hit
                     && (32'(w_occ) >= w_cap_eff);
    assign w_ins_idx = (w_evict && (!w_res.free_found || (w_res.old_idx < w_res.free_idx)))
                       ? w_res.old_idx : w_res.free_idx;

    assign w_cmd.en      = w_upd_fire && (w_res.hit || (r_op == lkv_pkg::OP_PUT));
    assign w_cmd.touch   = w_res.hit;
    assign w_cmd.insert  = (r_op == lkv_pkg::OP_PUT) && !w_res.hit;
    assign w_cmd.evict   = w_evict;
    assign w_cmd.hit_idx = w_res.hit_idx;
    assign w_cmd.old_idx = w_res.old_idx;
    assign w_cmd.ins_idx = w_ins_idx;

    assign w_key_we    = w_upd_fire && (r_op == lkv_pkg::OP_PUT) && !w_res.hit;
    assign w_val_we    = w_upd_fire && (r_op == lkv_pkg::OP_PUT);
    assign w_val_waddr = w_res.hit ? w_res.hit_idx : w_ins_idx;

    // Key and value stores
    lkv_ram #(
        .WIDTH (lkv_pkg::KEY_W),
        .DEPTH (lkv_pkg::ENTRIES)
    ) u_key_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_key_we),
        .i_wr_addr (w_ins_idx),
        .i_wr_data (r_key),
        .i_rd_en   (r_state == ST_SCAN),
        .i_rd_addr (r_idx),
        .o_rd_data (w_key_rd)
    );

    lkv_ram #(
        .WIDTH (lkv_pkg::VAL_W),
        .DEPTH (lkv_pkg::ENTRIES)
    ) u_val_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_val_we),
        .i_wr_addr (w_val_waddr),
        .i_wr_data (r_wval),
        .i_rd_en   (r_state == ST_SCAN),
        .i_rd_addr (r_idx),
        .o_rd_data (w_val_rd)
    );

    lkv_scan_unit u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .i_key    (r_key),
        .i_key_rd (w_key_rd),
        .i_val_rd (w_val_rd),
        .i_valid  (w_valid),
        .i_rank   (w_rank),
        .o_res    (w_res)
    );

    lkv_rank_array u_rank (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_valid (w_valid),
        .o_rank  (w_rank),
        .o_occ   (w_occ)
    );

    // Response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_upd_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_upd_fire) begin
            r_out_found <= w_res.hit;
            if (r_op == lkv_pkg::OP_PUT) begin
                r_out_val <= r_wval;
            end else if (w_res.hit) begin
                r_out_val <= w_res.hit_val;
            end else begin
                r_out_val <= '1;
            end
            r_out_ev    <= w_evict;
            r_out_evkey <= w_evict ? w_res.old_key : '0;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.found       = r_out_found;
    assign o_rsp.read_value  = r_out_val;
    assign o_rsp.evicted     = r_out_ev;
    assign o_rsp.evicted_key = r_out_evkey;

    // Checks
    a_occ_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid) == 32'(w_occ))
        else $error("occupancy does not match valid marks");

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(w_occ) <= 32'(lkv_pkg::ENTRIES))
        else $error("occupancy above store size");

    a_evict_keeps_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_upd_fire && w_evict) |=> (w_occ == $past(w_occ)))
        else $error("eviction with insert changed occupancy");

    a_evict_needs_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_upd_fire && w_evict) |-> (w_res.old_found && !w_res.hit))
        else $error("eviction without a least recent entry");

endmodule
